FILE: rtl/agfm_pkg.sv
// ----------------------------------------------------------------------------
// agfm_pkg
// Shared types and constants for the adaptive gate frequency meter.
// ----------------------------------------------------------------------------
package agfm_pkg;

  localparam int CHANNELS_DEF     = 8;
  localparam int COUNTER_BITS_DEF = 32;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [31:0] REF_HZ_RESET   = 32'd100000000;
  localparam logic [9:0]  MT_RESET       = 10'd10;
  localparam logic [7:0]  ENABLE_RESET   = 8'hFF;
  localparam logic [9:0]  MT_MAX         = 10'd1000;
  localparam logic [31:0] PENDING_RESET  = 32'd10;
  localparam logic [31:0] ACTIVE_RESET   = 32'd1;

  // register indexes
  localparam logic [1:0] REG_REF_HZ = 2'd0;
  localparam logic [1:0] REG_MT     = 2'd1;
  localparam logic [1:0] REG_ENABLE = 2'd2;
  localparam logic [1:0] REG_GRAY   = 2'd3;

  // divider sizes
  localparam int DVD_W = 80;
  localparam int DVS_W = 42;

  typedef struct packed {
    logic [2:0]  ch;
    logic        in_range;
    logic        enabled;
    logic        sig;
    logic [31:0] elapsed;
  } item_t;

  typedef struct packed {
    logic [2:0]  ch;
    logic        valid_res;
    logic [31:0] elapsed;
    logic [31:0] periods;
    logic [47:0] freq;
    logic [31:0] reload;
    logic [31:0] captures;
  } result_t;

  function automatic logic [31:0] gray_low(input logic [31:0] v, input logic en);
    logic [3:0] g;
    g = v[3:0];
    g = g ^ (g >> 1) ^ (g >> 2) ^ (g >> 3);
    gray_low = en ? {v[31:4], g} : v;
  endfunction

endpackage

FILE: rtl/adaptive_gate_frequency_meter.sv
// ----------------------------------------------------------------------------
// adaptive_gate_frequency_meter
// Multi-channel reciprocal frequency meter with an adaptive gate length.
// ----------------------------------------------------------------------------
// Path: a capture beat enters the queue; the back part takes it when idle.
// When a frequency is computed it runs two multiply states (S_MUL, S_MUL2),
// then two 80-step divisions in turn on one shared divider, then S_OUT;
// otherwise it goes straight to S_OUT. The back part takes a new item only
// after the last result is loaded into the output register, so output stalls
// hold it. Reset (rst, synchronous): registers to defaults, pending reload 10,
// active reload 1, capture counts 0, queue and output emptied.
module adaptive_gate_frequency_meter #(
  parameter int CHANNELS     = agfm_pkg::CHANNELS_DEF,
  parameter int COUNTER_BITS = agfm_pkg::COUNTER_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // capture stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,   // start_count[31:0], stop_count[63:32]
  input  logic [3:0]   s_tuser,   // channel[2:0], edges_seen[3]
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [175:0] m_tdata,   // elapsed_ticks, periods, frequency_q16(48),
                                  // next_gate, capture_count
  output logic [3:0]   m_tuser,   // out_channel[2:0], valid_res[3]
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import agfm_pkg::*;

  logic [31:0] reference_hz;
  logic [9:0]  gate_time;
  logic [7:0]  channel_enable;
  logic        gray_low_bits;

  item_t   f_item;
  item_t   q_item;
  logic    q_full;
  logic    q_empty;
  logic    q_pop;
  result_t res;

  assign pready = 1'b1;

  // register file: write on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      reference_hz    <= REF_HZ_RESET;
      gate_time       <= MT_RESET;
      channel_enable  <= ENABLE_RESET;
      gray_low_bits   <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_REF_HZ: reference_hz    <= pwdata;
        REG_MT:     gate_time       <= pwdata[9:0];
        REG_ENABLE: channel_enable  <= pwdata[7:0];
        REG_GRAY:   gray_low_bits   <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_REF_HZ: prdata = reference_hz;
      REG_MT:     prdata = {22'd0, gate_time};
      REG_ENABLE: prdata = {24'd0, channel_enable};
      REG_GRAY:   prdata = {31'd0, gray_low_bits};
    endcase
  end

  // front: decode and classify each capture beat
  agfm_front #(.CHANNELS(CHANNELS), .COUNTER_BITS(COUNTER_BITS)) u_front (
    .channel        (s_tuser[2:0]),
    .start_count    (s_tdata[31:0]),
    .stop_count     (s_tdata[63:32]),
    .edges_seen     (s_tuser[3]),
    .channel_enable (channel_enable),
    .gray_low_bits  (gray_low_bits),
    .item           (f_item)
  );

  assign s_tready = !q_full;

  agfm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_tvalid),
    .push_item (f_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_item),
    .empty     (q_empty)
  );

  // back: state update and arithmetic, holds the result until taken
  agfm_back #(.CHANNELS(CHANNELS)) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_empty         (q_empty),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .reference_hz    (reference_hz),
    .gate_time       (gate_time),
    .res_valid       (m_tvalid),
    .res_ready       (m_tready),
    .res             (res)
  );

  assign m_tuser = {res.valid_res, res.ch};
  assign m_tdata = {res.captures, res.reload, res.freq, res.periods, res.elapsed};

endmodule

FILE: rtl/agfm_front.sv
// ----------------------------------------------------------------------------
// agfm_front
// Decode captures, compute elapsed ticks and classify the channel.
// ----------------------------------------------------------------------------
module agfm_front #(
  parameter int CHANNELS     = agfm_pkg::CHANNELS_DEF,
  parameter int COUNTER_BITS = agfm_pkg::COUNTER_BITS_DEF
) (
  input  logic [2:0]      channel,
  input  logic [31:0]     start_count,
  input  logic [31:0]     stop_count,
  input  logic            edges_seen,
  input  logic [7:0]      channel_enable,
  input  logic            gray_low_bits,
  output agfm_pkg::item_t item
);
  import agfm_pkg::*;

  localparam logic [31:0] TOP = 32'((64'd1 << COUNTER_BITS) - 64'd1);

  logic [31:0] start_d;
  logic [31:0] stop_d;
  logic [31:0] diff;

  always_comb begin
    start_d = gray_low(start_count, gray_low_bits);
    stop_d  = gray_low(stop_count, gray_low_bits);
    diff    = stop_d - start_d;
    item.ch       = channel;
    item.sig      = edges_seen;
    item.in_range = ({29'd0, channel} < 32'(CHANNELS));
    item.enabled  = channel_enable[channel];
    // wrap correction for a counter narrower than the word
    item.elapsed  = diff[31] ? (TOP - start_d + stop_d) : diff;
  end

endmodule

FILE: rtl/agfm_queue.sv
// ----------------------------------------------------------------------------
// agfm_queue
// Short FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module agfm_queue #(
  parameter int DEPTH = agfm_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  agfm_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output agfm_pkg::item_t pop_item,
  output logic            empty
);
  import agfm_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t          entries [DEPTH];
  logic [PW-1:0]  wptr;
  logic [PW-1:0]  rptr;
  logic [CW-1:0]  count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_item = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push && !full) begin
        entries[wptr] <= push_item;
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop && !empty) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CW'(push && !full) - CW'(pop && !empty);
    end
  end

endmodule

FILE: rtl/agfm_divider.sv
// ----------------------------------------------------------------------------
// agfm_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module agfm_divider #(
  parameter int DVD_W = agfm_pkg::DVD_W,
  parameter int DVS_W = agfm_pkg::DVS_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);
  localparam int CW = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVD_W-1:0] shreg;
  logic [CW-1:0]    left;
  logic [DVS_W:0]   trial;
  logic             fit;

  assign quotient = shreg;
  assign trial    = {rem, shreg[DVD_W-1]};
  assign fit      = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        left  <= CW'(DVD_W);
        rem   <= '0;
        dvs   <= divisor;
        shreg <= dividend;
      end else if (left != '0) begin
        rem   <= fit ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];
        shreg <= {shreg[DVD_W-2:0], fit};
        left  <= left - 1'b1;
        done  <= (left == CW'(1));
      end
    end
  end

endmodule

FILE: rtl/agfm_back.sv
// ----------------------------------------------------------------------------
// agfm_back
// Per-channel state, frequency and next reload computation.
// ----------------------------------------------------------------------------
module agfm_back #(
  parameter int CHANNELS = agfm_pkg::CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  agfm_pkg::item_t   q_item,
  output logic              q_pop,
  input  logic [31:0]       reference_hz,
  input  logic [9:0]        gate_time,
  output logic              res_valid,
  input  logic              res_ready,
  output agfm_pkg::result_t res
);
  import agfm_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_MUL2 = 3'd2;
  localparam logic [2:0] S_DIV1 = 3'd3;
  localparam logic [2:0] S_DIV2 = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]  state;
  logic [31:0] pending [CHANNELS];
  logic [31:0] active  [CHANNELS];
  logic [31:0] seen    [CHANNELS];

  item_t          cur;
  result_t        acc;
  logic [CH_W-1:0] idx;
  logic [CH_W+2:0] chx;
  logic [CH_W-1:0] qidx;
  logic [63:0]    num;
  logic [41:0]    dvs2;
  logic [41:0]    xlo;
  logic [41:0]    xhi;
  logic [73:0]    xsum;
  logic [9:0]     mt;
  logic [31:0]    nact;
  logic [31:0]    nr;
  logic           res_load;
  logic           do_math;

  logic             div_start;
  logic [DVD_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic             div_done;
  logic [DVD_W-1:0] div_q;

  assign chx  = {{CH_W{1'b0}}, q_item.ch};
  assign qidx = chx[CH_W-1:0];
  assign mt   = (gate_time > MT_MAX) ? MT_MAX : gate_time;
  assign xsum = {xhi, 32'd0} + {32'd0, xlo};
  assign q_pop = (state == S_IDLE) && !q_empty;
  assign res_load = (state == S_OUT) && (!res_valid || res_ready);
  assign do_math  = q_item.sig && (q_item.elapsed != '0) && (active[qidx] != '0);

  always_comb begin
    nact = (pending[qidx] == '0) ? 32'd1 : pending[qidx];
    if (div_q[79:32] != '0) begin
      nr = '1;
    end else if (div_q[31:0] == '0) begin
      nr = 32'd1;
    end else begin
      nr = div_q[31:0];
    end
    div_start = 1'b0;
    div_dvd   = {num, 16'd0};
    div_dvs   = {10'd0, cur.elapsed};
    if (state == S_MUL2) begin
      div_start = 1'b1;
    end else if (state == S_DIV1 && div_done) begin
      div_start = 1'b1;
      div_dvd   = {6'd0, xsum};
      div_dvs   = dvs2;
    end
  end

  agfm_divider #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        pending[c] <= PENDING_RESET;
        active[c]  <= ACTIVE_RESET;
        seen[c]    <= '0;
      end
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cur           <= q_item;
            idx           <= qidx;
            acc.ch        <= q_item.ch;
            acc.valid_res <= 1'b0;
            acc.freq      <= '0;
            if (q_item.in_range && q_item.enabled) begin
              // advance the reload pipeline now; pending waits for the result
              acc.elapsed  <= q_item.elapsed;
              acc.periods  <= active[qidx];
              acc.reload   <= nact;
              acc.captures <= seen[qidx] + 1'b1;
              active[qidx] <= nact;
              seen[qidx]   <= seen[qidx] + 1'b1;
              state        <= do_math ? S_MUL : S_OUT;
            end else begin
              acc.elapsed  <= '0;
              acc.periods  <= '0;
              acc.reload   <= q_item.in_range ? active[qidx] : '0;
              acc.captures <= q_item.in_range ? seen[qidx] : '0;
              state        <= S_OUT;
            end
          end
        end
        S_MUL: begin
          num   <= acc.periods * reference_hz;
          dvs2  <= cur.elapsed * 10'd1000;
          state <= S_MUL2;
        end
        S_MUL2: begin
          xlo   <= num[31:0] * mt;
          xhi   <= num[63:32] * mt;
          state <= S_DIV1;
        end
        S_DIV1: begin
          if (div_done) begin
            acc.freq <= (div_q[79:48] != '0) ? '1 : div_q[47:0];
            state    <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (div_done) begin
            pending[idx]  <= nr;
            acc.valid_res <= 1'b1;
            state         <= S_OUT;
          end
        end
        S_OUT: begin
          if (res_load) begin
            res   <= acc;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
